[hw/rtl/scseg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_pkg
// Shared widths, register indexes, control structs and helpers of the scan
// segmenter.
// ----------------------------------------------------------------------------
package scseg_pkg;

  localparam int unsigned IndexWidth  = 32;
  localparam int unsigned OutWidth    = 32;
  localparam int unsigned StatusWidth = 16;
  localparam int unsigned LenWidth    = 24;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = LenWidth;

  localparam logic [StatusWidth-1:0] ScanTypeStraight = StatusWidth'(3);
  localparam int unsigned            HoldTurnBit      = 3;
  localparam logic [LenWidth-1:0]    MinLengthReset   = LenWidth'(128);

  typedef logic [IndexWidth-1:0] idx_t;
  typedef logic [LenWidth-1:0]   len_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_TURN_SOURCE  = 2'd0,
    REG_CHUNK_LENGTH = 2'd1,
    REG_MIN_LENGTH   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic turn_source;
    len_t chunk_length;
    len_t min_length;
  } cfg_t;

  typedef struct packed {
    logic emit;
    idx_t start;
    idx_t stop;
    logic final_scan;
  } res_t;

  function automatic idx_t sat_inc(input idx_t v);
    idx_t r;
    r = (v == '1) ? v : v + idx_t'(1);
    return r;
  endfunction

  // length of [s, e] against the effective minimum
  function automatic logic long_enough(input idx_t s, input idx_t e, input len_t m);
    logic [IndexWidth:0] len;
    len = (e >= s) ? ({1'b0, e - s} + (IndexWidth+1)'(1)) : '0;
    return len >= (IndexWidth+1)'(m);
  endfunction

endpackage

[hw/rtl/scseg_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_in_if
// Sample channel: one status word per handshake.
// ----------------------------------------------------------------------------
interface scseg_in_if;
  import scseg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatusWidth-1:0] status_value;
  logic                   last_sample;

  modport source (output valid, output status_value, output last_sample, input ready);
  modport sink   (input valid, input status_value, input last_sample, output ready);
endinterface

[hw/rtl/scseg_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_out_if
// Scan channel: start and end index of one kept scan per word.
// ----------------------------------------------------------------------------
interface scseg_out_if;
  import scseg_pkg::*;

  logic                valid;
  logic                ready;
  logic [OutWidth-1:0] scan_start;
  logic [OutWidth-1:0] scan_end;
  logic                final_scan;

  modport source (output valid, output scan_start, output scan_end, output final_scan,
                  input ready);
  modport sink   (input valid, input scan_start, input scan_end, input final_scan,
                  output ready);
endinterface

[hw/rtl/scseg_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_cfg
// Configuration register file: turn source, chunk length, minimum length.
// ----------------------------------------------------------------------------
module scseg_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scseg_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [scseg_pkg::CfgWidth-1:0]       cfg_data_i,
  output scseg_pkg::cfg_t                      cfg_o
);
  import scseg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TURN_SOURCE:  cfg_d.turn_source  = cfg_data_i[0];
        REG_CHUNK_LENGTH: cfg_d.chunk_length = cfg_data_i[LenWidth-1:0];
        REG_MIN_LENGTH:   cfg_d.min_length   = cfg_data_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_source  <= 1'b0;
      cfg_q.chunk_length <= '0;
      cfg_q.min_length   <= MinLengthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/scseg_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_track
// Per-sample raster edge tracker and chunk counter; produces at most one
// scan per sample and updates the stream state on each step.
// ----------------------------------------------------------------------------
module scseg_track (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  scseg_pkg::cfg_t                      cfg_i,
  input  logic                                 step_i,
  input  logic [scseg_pkg::StatusWidth-1:0]    status_i,
  input  logic                                 last_i,
  output scseg_pkg::res_t                      res_o
);
  import scseg_pkg::*;

  idx_t sample_index_q, sample_index_d;
  logic prev_turning_q, prev_turning_d;
  idx_t open_start_q, open_start_d;
  logic scan_open_q, scan_open_d;
  logic held_valid_q, held_valid_d;
  idx_t held_start_q, held_start_d;
  idx_t held_end_q, held_end_d;
  len_t chunk_pos_q, chunk_pos_d;

  logic turning, fell, rose;
  len_t min_eff;
  logic r_emit, c_emit, chunk_done;
  idx_t rs, re, cs;
  idx_t tail_start;

  always_comb begin
    min_eff = (cfg_i.min_length == '0) ? len_t'(1) : cfg_i.min_length;
    turning = cfg_i.turn_source ? (status_i != ScanTypeStraight) : status_i[HoldTurnBit];
    fell    = (sample_index_q != '0) && prev_turning_q && !turning;
    rose    = (sample_index_q != '0) && !prev_turning_q && turning;

    open_start_d = open_start_q;
    scan_open_d  = scan_open_q;
    held_valid_d = held_valid_q;
    held_start_d = held_start_q;
    held_end_d   = held_end_q;
    r_emit       = 1'b0;
    rs           = held_start_q;
    re           = held_end_q;

    // raster edges
    if (sample_index_q == '0) begin
      if (!turning) begin
        scan_open_d  = 1'b1;
        open_start_d = idx_t'(1);
      end
    end else if (fell) begin
      r_emit       = held_valid_q && long_enough(held_start_q, held_end_q, min_eff);
      held_valid_d = 1'b0;
      scan_open_d  = 1'b1;
      open_start_d = sat_inc(sample_index_q);
    end else if (rose && scan_open_q) begin
      held_valid_d = 1'b1;
      held_start_d = open_start_q;
      held_end_d   = sample_index_q - idx_t'(1);
      scan_open_d  = 1'b0;
    end

    // last scan stretches to the final sample
    tail_start = scan_open_d ? open_start_d : held_start_d;
    if (last_i && !fell && (scan_open_d || held_valid_d)) begin
      r_emit = long_enough(tail_start, sample_index_q, min_eff);
      rs     = tail_start;
      re     = sample_index_q;
    end

    // fixed chunks
    chunk_done = (cfg_i.chunk_length != '0) &&
                 (({1'b0, chunk_pos_q} + (LenWidth+1)'(1)) >= {1'b0, cfg_i.chunk_length});
    cs         = sample_index_q - IndexWidth'(chunk_pos_q);
    c_emit     = chunk_done && long_enough(cs, sample_index_q, min_eff) &&
                 (cfg_i.chunk_length >= min_eff);
    chunk_pos_d = chunk_done ? '0 : chunk_pos_q + len_t'(1);

    prev_turning_d = turning;
    sample_index_d = sat_inc(sample_index_q);

    if (last_i) begin
      sample_index_d = '0;
      prev_turning_d = 1'b0;
      open_start_d   = '0;
      scan_open_d    = 1'b0;
      held_valid_d   = 1'b0;
      held_start_d   = '0;
      held_end_d     = '0;
      chunk_pos_d    = '0;
    end

    if (cfg_i.chunk_length == '0) begin
      res_o.emit  = r_emit;
      res_o.start = rs;
      res_o.stop  = re;
    end else begin
      res_o.emit  = c_emit;
      res_o.start = cs;
      res_o.stop  = sample_index_q;
    end
    res_o.final_scan = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      prev_turning_q <= 1'b0;
      open_start_q   <= '0;
      scan_open_q    <= 1'b0;
      held_valid_q   <= 1'b0;
      held_start_q   <= '0;
      held_end_q     <= '0;
      chunk_pos_q    <= '0;
    end else if (step_i) begin
      sample_index_q <= sample_index_d;
      prev_turning_q <= prev_turning_d;
      open_start_q   <= open_start_d;
      scan_open_q    <= scan_open_d;
      held_valid_q   <= held_valid_d;
      held_start_q   <= held_start_d;
      held_end_q     <= held_end_d;
      chunk_pos_q    <= chunk_pos_d;
    end
  end

endmodule

[hw/rtl/scan_segmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_segmenter
// Splits a stream of telescope status samples into scans.
// ----------------------------------------------------------------------------
// Usage: samples enter on in_i (status word plus last_sample flag), one word
// per valid/ready handshake. Kept scans leave on out_o as start/end sample
// indexes; final_scan marks a scan emitted on the last sample. A sample gives
// zero or one scan word.
// Throughput is one sample per cycle while out_o does not stall. A sample
// waits in the input register, the edge and chunk logic works on it as it
// advances and the scan lands in the output register, where the scan word
// stays valid until out_o takes it.
// The input and output registers are the only buffers: while out_o stalls
// with a word in it, one more sample may wait in the input register, then in_i.ready drops.
// Reset clears the stream state (index zero, no open or held scan) and loads
// register defaults: turn source bit, raster mode, minimum length 128.
// Configuration writes via cfg_we_i/cfg_index_i/cfg_data_i take effect the
// next cycle and are meant for an idle block.
// ----------------------------------------------------------------------------
module scan_segmenter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [scseg_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [scseg_pkg::CfgWidth-1:0]    cfg_data_i,
  scseg_in_if.sink                          in_i,
  scseg_out_if.source                       out_o
);
  import scseg_pkg::*;

  cfg_t cfg;
  res_t res;

  logic                   in_valid_q, in_valid_d;
  logic [StatusWidth-1:0] in_status_q;
  logic                   in_last_q;
  logic                   out_valid_q, out_valid_d;
  logic [OutWidth-1:0]    out_start_q, out_end_q;
  logic                   out_final_q;
  logic                   advance, in_fire;

  scseg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  scseg_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .status_i (in_status_q),
    .last_i   (in_last_q),
    .res_o    (res)
  );

  // the sample in the input register moves on when the output slot frees up
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_status_q <= in_i.status_value;
      in_last_q   <= in_i.last_sample;
    end
    if (advance && res.emit) begin
      out_start_q <= OutWidth'(res.start);
      out_end_q   <= OutWidth'(res.stop);
      out_final_q <= res.final_scan;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scan_start = out_start_q;
  assign out_o.scan_end   = out_end_q;
  assign out_o.final_scan = out_final_q;

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input not ready although the output register is empty");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while both stages are full and stalled");

  a_scan_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_end_q >= out_start_q))
    else $error("scan word ends before it starts");

endmodule
